FILE: rtl/lsfe_pkg.sv
// Shared types, constants and the SPI bit-code function for the LED strip frame encoder.
package lsfe_pkg;

  localparam int MAX_LEDS_DEF = 64;

  localparam int CNT_W      = 7;   // led_count width
  localparam int POS_W      = 6;   // pixel position width
  localparam int CH_W       = 8;   // one colour channel
  localparam int PIX_W      = 3 * CH_W;
  localparam int CODE_W     = 8 * CH_W;
  localparam int OFS_W      = 16;
  localparam int DIV_W      = OFS_W + 1;
  localparam int BCNT_W     = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CH_W-1:0]  BRIGHT_RST = 8'd255;
  localparam logic [CNT_W-1:0] COUNT_RST  = 7'd64;

  localparam logic [7:0] CODE_ONE  = 8'h1F;
  localparam logic [7:0] CODE_ZERO = 8'h07;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 1'b1;

  typedef struct packed {
    logic load;
    logic wr_step;
    logic mod_step;
    logic rd;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic item_op;
    logic range_empty;
    logic n_zero;
    logic wr_last;
    logic mod_last;
    logic tag_last;
    logic out_free;
  } sts_t;

  // MSB of the channel lands in the top byte
  function automatic logic [CODE_W-1:0] encode_channel(input logic [CH_W-1:0] v);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int b = 0; b < CH_W; b++) begin
      code[8*b +: 8] = v[b] ? CODE_ONE : CODE_ZERO;
    end
    return code;
  endfunction

endpackage

FILE: rtl/led_strip_spi_frame_encoder_top.sv
// LED strip SPI frame encoder: pixel store, brightness scaling and SPI bit coding.
//
// Input words (in_valid/in_stall) carry either a range write or a refresh.
// A range write stores one colour at positions first..last below the strip
// length; it keeps the block busy while it steps through first..last and gives
// no words. A refresh first reduces the rotation offset plus n-1 modulo the
// strip length n (one dividend bit per cycle), then walks the pixels from the
// rotated top position downward, each pixel going through a memory read, a
// scale and an output load, giving one result word per pixel, last set on the
// final one. in_stall is high while an item runs.
// One output register holds the result word; while out_stall is high the
// word holds and the walk waits in front of it.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 brightness,
// index 1 led_count; write only while idle.
// Reset: brightness 255, led_count 64, every pixel reads black at once
// through per-entry valid bits; no clearing pass.
module led_strip_spi_frame_encoder_top #(
  parameter int MAX_LEDS = lsfe_pkg::MAX_LEDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsfe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [lsfe_pkg::POS_W-1:0]      in_first_index,
  input  logic [lsfe_pkg::POS_W-1:0]      in_last_index,
  input  logic [lsfe_pkg::CH_W-1:0]       in_red,
  input  logic [lsfe_pkg::CH_W-1:0]       in_green,
  input  logic [lsfe_pkg::CH_W-1:0]       in_blue,
  input  logic [lsfe_pkg::OFS_W-1:0]      in_rotate_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lsfe_pkg::CODE_W-1:0]     out_red_code,
  output logic [lsfe_pkg::CODE_W-1:0]     out_green_code,
  output logic [lsfe_pkg::CODE_W-1:0]     out_blue_code,
  output logic [lsfe_pkg::POS_W-1:0]      out_pixel_position,
  output logic                            out_last
);
  import lsfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsfe_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_first_index     (in_first_index),
    .in_last_index      (in_last_index),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_rotate_offset   (in_rotate_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_red_code       (out_red_code),
    .out_green_code     (out_green_code),
    .out_blue_code      (out_blue_code),
    .out_pixel_position (out_pixel_position),
    .out_last           (out_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

FILE: rtl/lsfe_ctrl.sv
// Sequencer for range writes, rotation remainder and the per-pixel refresh walk.
module lsfe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lsfe_pkg::sts_t sts,
  output lsfe_pkg::cmd_t cmd
);
  import lsfe_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WRITE = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_SCALE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.item_op == OP_WRITE) begin
            if (!sts.range_empty) state_nxt = S_WRITE;
          end else if (!sts.n_zero) begin
            state_nxt = S_MOD;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.wr_last) state_nxt = S_IDLE;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.tag_last ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output word still held");

  a_refresh_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && sts.item_op == OP_REFRESH && !sts.n_zero)
      |=> state_r == S_MOD)
    else $error("refresh did not start rotation remainder");
`endif

endmodule

FILE: rtl/lsfe_dp.sv
// Datapath: config registers, pixel memory, remainder unit, scaling and output word.
module lsfe_dp #(
  parameter int MAX_LEDS = lsfe_pkg::MAX_LEDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_operation,
  input  logic [lsfe_pkg::POS_W-1:0]        in_first_index,
  input  logic [lsfe_pkg::POS_W-1:0]        in_last_index,
  input  logic [lsfe_pkg::CH_W-1:0]         in_red,
  input  logic [lsfe_pkg::CH_W-1:0]         in_green,
  input  logic [lsfe_pkg::CH_W-1:0]         in_blue,
  input  logic [lsfe_pkg::OFS_W-1:0]        in_rotate_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lsfe_pkg::CODE_W-1:0]       out_red_code,
  output logic [lsfe_pkg::CODE_W-1:0]       out_green_code,
  output logic [lsfe_pkg::CODE_W-1:0]       out_blue_code,
  output logic [lsfe_pkg::POS_W-1:0]        out_pixel_position,
  output logic                              out_last,
  input  lsfe_pkg::cmd_t                    cmd,
  output lsfe_pkg::sts_t                    sts
);
  import lsfe_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_LEDS);

  // config
  logic [CH_W-1:0]  bright_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_w;

  // item / walk state
  logic [POS_W-1:0]  p_r, last_r, pos_r;
  logic [PIX_W-1:0]  color_r;
  logic [DIV_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    rem_t;
  logic [BCNT_W-1:0] bcnt_r;
  logic [CNT_W-1:0]  left_r;

  // pixel store
  logic [PIX_W-1:0]    mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] vld_r;
  logic [PIX_W-1:0]    rd_data_r, px_w;
  logic                rd_vld_r;
  logic [POS_W-1:0]    tag_pos_r;
  logic                tag_last_r;
  logic                wr_en;

  logic [CH_W-1:0] sc_red_r, sc_green_r, sc_blue_r;
  logic [2*CH_W-1:0] prod_red, prod_green, prod_blue;

  logic out_valid_r;
  logic [CODE_W-1:0] red_code_r, green_code_r, blue_code_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_last_r;

  assign cfg_ready = 1'b1;
  assign n_w = (count_r > MAX_N) ? MAX_N : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RST;
      count_r  <= COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: bright_r <= cfg_data;
        CFG_LED_COUNT:  count_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // one bit of offset+n-1 per step, restoring remainder by n
  assign rem_t   = {rem_r, div_r[DIV_W-1]};
  assign rem_nxt = (rem_t >= {1'b0, n_w}) ? CNT_W'(rem_t - {1'b0, n_w})
                                          : rem_t[CNT_W-1:0];

  assign wr_en = cmd.wr_step && ({1'b0, p_r} < n_w);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r     <= in_first_index;
      last_r  <= in_last_index;
      color_r <= {in_red, in_green, in_blue};
      div_r   <= DIV_W'({1'b0, in_rotate_offset} + DIV_W'(n_w) - DIV_W'(1));
      rem_r   <= '0;
      bcnt_r  <= '0;
      left_r  <= n_w;
    end else begin
      if (cmd.wr_step) p_r <= p_r + POS_W'(1);
      if (cmd.mod_step) begin
        rem_r  <= rem_nxt;
        div_r  <= {div_r[DIV_W-2:0], 1'b0};
        bcnt_r <= bcnt_r + BCNT_W'(1);
        if (bcnt_r == BCNT_W'(DIV_W - 1)) pos_r <= rem_nxt[POS_W-1:0];
      end
      if (cmd.rd) begin
        left_r     <= left_r - CNT_W'(1);
        pos_r      <= (pos_r == '0) ? POS_W'(n_w - CNT_W'(1)) : pos_r - POS_W'(1);
        tag_pos_r  <= pos_r;
        tag_last_r <= (left_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[p_r[AW-1:0]] <= color_r;
    if (cmd.rd) begin
      rd_data_r <= mem[pos_r[AW-1:0]];
      rd_vld_r  <= vld_r[pos_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[p_r[AW-1:0]] <= 1'b1;
    end
  end

  // never-written entries read as black
  assign px_w       = rd_vld_r ? rd_data_r : '0;
  assign prod_red   = {{CH_W{1'b0}}, px_w[3*CH_W-1 -: CH_W]} * {{CH_W{1'b0}}, bright_r};
  assign prod_green = {{CH_W{1'b0}}, px_w[2*CH_W-1 -: CH_W]} * {{CH_W{1'b0}}, bright_r};
  assign prod_blue  = {{CH_W{1'b0}}, px_w[CH_W-1:0]} * {{CH_W{1'b0}}, bright_r};

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      sc_red_r   <= prod_red[2*CH_W-1:CH_W];
      sc_green_r <= prod_green[2*CH_W-1:CH_W];
      sc_blue_r  <= prod_blue[2*CH_W-1:CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red_code_r   <= encode_channel(sc_red_r);
      green_code_r <= encode_channel(sc_green_r);
      blue_code_r  <= encode_channel(sc_blue_r);
      out_pos_r    <= tag_pos_r;
      out_last_r   <= tag_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_code       = red_code_r;
  assign out_green_code     = green_code_r;
  assign out_blue_code      = blue_code_r;
  assign out_pixel_position = out_pos_r;
  assign out_last           = out_last_r;

  always_comb begin
    sts             = '0;
    sts.item_op     = in_operation;
    sts.range_empty = in_last_index < in_first_index;
    sts.n_zero      = (n_w == '0);
    sts.wr_last     = (p_r == last_r);
    sts.mod_last    = (bcnt_r == BCNT_W'(DIV_W - 1));
    sts.tag_last    = tag_last_r;
    sts.out_free    = !out_valid_r || !out_stall;
  end

`ifndef ASSERT_OFF
  a_rd_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> ({1'b0, pos_r} < n_w))
    else $error("refresh read outside strip");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |=> rem_r < n_w)
    else $error("remainder not reduced below strip length");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && tag_last_r) |-> left_r == '0)
    else $error("last pixel flagged with pixels left");
`endif

endmodule
